// ----- hdl/pm_sensor_frame_parser_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame parser
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PM_SENSOR_FRAME_PARSER_MACROS_SVH
`define PM_SENSOR_FRAME_PARSER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PM_SFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PM_SFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pm_sfp_pkg.sv -----
// ---------------------------------------------------------------------------
// Sensor frame parser package
// Types, frame positions and register defaults shared by the parser files.
// ---------------------------------------------------------------------------
package pm_sfp_pkg;

  localparam int unsigned CfgIdxW = 4;

  // Frame byte positions
  localparam logic [7:0] PosHeader0 = 8'd0;
  localparam logic [7:0] PosHeader1 = 8'd1;
  localparam logic [7:0] PosPm25Lo  = 8'd2;
  localparam logic [7:0] PosPm25Hi  = 8'd3;
  localparam logic [7:0] PosPm10Lo  = 8'd4;
  localparam logic [7:0] PosPm10Hi  = 8'd5;
  localparam logic [7:0] PosSumLast = 8'd7;
  localparam logic [7:0] PosCheck   = 8'd8;
  localparam logic [7:0] PosTail    = 8'd9;
  localparam logic [7:0] CountMax   = 8'hFF;

  // Register defaults
  localparam logic [7:0] HeaderFirstRst  = 8'd170;
  localparam logic [7:0] HeaderSecondRst = 8'd192;
  localparam logic [7:0] TailValueRst    = 8'd171;
  localparam logic [7:0] MinLengthRst    = 8'd10;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_FRAMING  = 2'd2,
    STATUS_CHECKSUM = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_FIRST  = 4'd0,
    REG_HEADER_SECOND = 4'd1,
    REG_TAIL_VALUE    = 4'd2,
    REG_MIN_LENGTH    = 4'd3
  } reg_idx_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_e;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] tail_value;
    logic [7:0] min_length;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
  } result_t;

endpackage

// ----- hdl/pm_sfp_core.sv -----
// ---------------------------------------------------------------------------
// Sensor frame parser core
// Per-burst frame state, updated one transaction at a time, and the verdict
// formed from that state for an end-of-burst item.
// ---------------------------------------------------------------------------
module pm_sfp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  pm_sfp_pkg::action_e  action_i,
  input  logic [7:0]           data_byte_i,
  input  pm_sfp_pkg::cfg_t     cfg_i,
  output pm_sfp_pkg::result_t  result_o
);

  logic [7:0]  cnt_q, cnt_d;
  logic        match_q, match_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  chk_q, chk_d;
  logic [15:0] pm25_q, pm25_d;
  logic [15:0] pm10_q, pm10_d;
  logic        frame_ok;

  always_comb begin
    cnt_d   = cnt_q;
    match_d = match_q;
    sum_d   = sum_q;
    chk_d   = chk_q;
    pm25_d  = pm25_q;
    pm10_d  = pm10_q;
    if (take_i) begin
      if (action_i == pm_sfp_pkg::ACT_BYTE) begin
        case (cnt_q)
          pm_sfp_pkg::PosHeader0: begin
            if (data_byte_i != cfg_i.header_first) match_d = 1'b0;
          end
          pm_sfp_pkg::PosHeader1: begin
            if (data_byte_i != cfg_i.header_second) match_d = 1'b0;
          end
          pm_sfp_pkg::PosTail: begin
            if (data_byte_i != cfg_i.tail_value) match_d = 1'b0;
          end
          pm_sfp_pkg::PosCheck:  chk_d = data_byte_i;
          pm_sfp_pkg::PosPm25Lo: pm25_d[7:0]  = data_byte_i;
          pm_sfp_pkg::PosPm25Hi: pm25_d[15:8] = data_byte_i;
          pm_sfp_pkg::PosPm10Lo: pm10_d[7:0]  = data_byte_i;
          pm_sfp_pkg::PosPm10Hi: pm10_d[15:8] = data_byte_i;
          default: ;
        endcase
        // payload bytes 2..7 feed the additive checksum
        if (cnt_q >= pm_sfp_pkg::PosPm25Lo && cnt_q <= pm_sfp_pkg::PosSumLast) begin
          sum_d = sum_q + data_byte_i;
        end
        if (cnt_q != pm_sfp_pkg::CountMax) cnt_d = cnt_q + 8'd1;
      end else begin
        cnt_d   = '0;
        match_d = 1'b1;
        sum_d   = '0;
        chk_d   = '0;
        pm25_d  = '0;
        pm10_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      match_q <= 1'b1;
      sum_q   <= '0;
      chk_q   <= '0;
      pm25_q  <= '0;
      pm10_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      match_q <= match_d;
      sum_q   <= sum_d;
      chk_q   <= chk_d;
      pm25_q  <= pm25_d;
      pm10_q  <= pm10_d;
    end
  end

  // Framing bytes never received compare as zero against the registers.
  always_comb begin
    frame_ok = match_q;
    if (cnt_q <= pm_sfp_pkg::PosHeader0 && cfg_i.header_first != 8'd0) frame_ok = 1'b0;
    if (cnt_q <= pm_sfp_pkg::PosHeader1 && cfg_i.header_second != 8'd0) frame_ok = 1'b0;
    if (cnt_q <= pm_sfp_pkg::PosTail && cfg_i.tail_value != 8'd0) frame_ok = 1'b0;

    result_o.pm25_tenths = '0;
    result_o.pm10_tenths = '0;
    if (cnt_q < cfg_i.min_length) begin
      result_o.status = pm_sfp_pkg::STATUS_SHORT;
    end else if (!frame_ok) begin
      result_o.status = pm_sfp_pkg::STATUS_FRAMING;
    end else if (sum_q != chk_q) begin
      result_o.status = pm_sfp_pkg::STATUS_CHECKSUM;
    end else begin
      result_o.status      = pm_sfp_pkg::STATUS_GOOD;
      result_o.pm25_tenths = pm25_q;
      result_o.pm10_tenths = pm10_q;
    end
  end

endmodule

// ----- hdl/pm_sensor_frame_parser.sv -----
// ---------------------------------------------------------------------------
// Particulate sensor frame parser
// Checks one reception burst per end item and reports status and PM values.
// ---------------------------------------------------------------------------
// Takes one transaction per clock on the input stream, bytes and end items
// alike. Each transaction is held in the input register and is then
// folded into the frame state; an end item loads its result into the output
// register when it leaves the input. The input only stalls when an end item
// waits in the input register while the output register holds an untaken
// result. Configuration writes are accepted every cycle; unknown indexes are
// dropped. Output tuser is the status, tdata carries PM2.5 and PM10 in tenths.
module pm_sensor_frame_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                     s_axis_tuser,  // [0] action
  // stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // [15:0] pm25, [31:16] pm10
  output logic [1:0]                     m_axis_tuser,  // [1:0] status
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pm_sfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  pm_sfp_pkg::cfg_t    cfg_q;
  logic                in_v_q;
  pm_sfp_pkg::action_e in_act_q;
  logic [7:0]          in_byte_q;
  logic                out_v_q;
  pm_sfp_pkg::result_t out_q;
  pm_sfp_pkg::result_t result;
  logic                out_free;
  logic                advance;
  logic                load_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= pm_sfp_pkg::HeaderFirstRst;
      cfg_q.header_second <= pm_sfp_pkg::HeaderSecondRst;
      cfg_q.tail_value    <= pm_sfp_pkg::TailValueRst;
      cfg_q.min_length    <= pm_sfp_pkg::MinLengthRst;
    end else if (cfg_valid_i) begin
      case (pm_sfp_pkg::reg_idx_e'(cfg_index_i))
        pm_sfp_pkg::REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data_i;
        pm_sfp_pkg::REG_HEADER_SECOND: cfg_q.header_second <= cfg_data_i;
        pm_sfp_pkg::REG_TAIL_VALUE:    cfg_q.tail_value    <= cfg_data_i;
        pm_sfp_pkg::REG_MIN_LENGTH:    cfg_q.min_length    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bytes always retire; an end item needs room in the output register.
  assign out_free      = !out_v_q || m_axis_tready;
  assign advance       = in_v_q && (in_act_q == pm_sfp_pkg::ACT_BYTE || out_free);
  assign load_out      = advance && in_act_q == pm_sfp_pkg::ACT_END;
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_act_q  <= pm_sfp_pkg::action_e'(s_axis_tuser[0]);
      in_byte_q <= s_axis_tdata;
    end
  end

  pm_sfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .action_i    (in_act_q),
    .data_byte_i (in_byte_q),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= (out_v_q && !m_axis_tready) || load_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= result;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.pm10_tenths, out_q.pm25_tenths};
  assign m_axis_tuser  = out_q.status;

endmodule

// ----- hdl/pm_sfp_checker.sv -----
// ---------------------------------------------------------------------------
// Sensor frame parser checker
// Port-level assertions, bound to the parser top level.
// ---------------------------------------------------------------------------
`include "pm_sensor_frame_parser_macros.svh"

module pm_sfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // failed frames never leak measurement values
  `PM_SFP_ASSERT_SAME(a_bad_frame_zero,
    m_axis_tvalid && m_axis_tuser != pm_sfp_pkg::STATUS_GOOD,
    m_axis_tdata == 32'd0, "non-good result carries PM data")

  `PM_SFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  // only a blocked end item may hold off the input, so a drained output frees it
  `PM_SFP_ASSERT_SAME(a_in_ready, !m_axis_tvalid && $past(!m_axis_tvalid),
    s_axis_tready, "input stalled with empty output")

  `PM_SFP_ASSERT_SAME(a_cfg_ready, cfg_valid_i, cfg_ready_o,
    "register write not taken")

endmodule

bind pm_sensor_frame_parser pm_sfp_checker u_pm_sfp_checker (.*);
